### rtl/core/q2rm_pkg.sv
// Package for the quaternion to rotation matrix unit.
// Holds the shared widths, register addresses and the cell data record.
// No dependencies.
package q2rm_pkg;

   localparam int CompW   = 16;
   localparam int SumW    = 33;
   localparam int NormW   = 17;
   localparam int RootSteps = 17;
   localparam int DivSteps  = 31;
   localparam int MinNormW  = 15;

   localparam logic [0:0] ADDR_ASSUME_UNIT = 1'b0;
   localparam logic [0:0] ADDR_MIN_NORM    = 1'b1;

   // Record handed from cell to cell along the chain
   typedef struct packed {
      logic                     vld;
      logic                     unit;
      logic [MinNormW-1:0]      min_norm;
      logic signed [CompW-1:0]  q_w;
      logic signed [CompW-1:0]  q_x;
      logic signed [CompW-1:0]  q_y;
      logic signed [CompW-1:0]  q_z;
      logic [SumW-1:0]          rem;
      logic [NormW-1:0]         root;
   } cell_type;

endpackage

### rtl/core/q2rm_root_cell.sv
// One cell of the square-root chain: settles one bit of the integer root.
// Uses q2rm_pkg.
module q2rm_root_cell #(
   parameter int Step = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  q2rm_pkg::cell_type cell_i,
   output q2rm_pkg::cell_type cell_o
);
   localparam int Bit = q2rm_pkg::RootSteps - 1 - Step;

   q2rm_pkg::cell_type cell_ff, cell_in;
   logic [q2rm_pkg::SumW+1:0] trial;
   logic [q2rm_pkg::SumW+1:0] rem_wide;

   // Restoring step: try root bit Bit
   always_comb begin
      cell_in  = cell_i;
      rem_wide = {2'b00, cell_i.rem};
      trial    = ({{(q2rm_pkg::SumW+2-q2rm_pkg::NormW){1'b0}}, cell_i.root} << (Bit + 1))
               + ((q2rm_pkg::SumW+2)'(1) << (2 * Bit));
      if (rem_wide >= trial) begin
         cell_in.rem  = q2rm_pkg::SumW'(rem_wide - trial);
         cell_in.root = cell_i.root | (q2rm_pkg::NormW'(1) << Bit);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.vld <= 1'b0;
      end else begin
         cell_ff.vld <= cell_in.vld;
      end
      cell_ff.unit     <= cell_in.unit;
      cell_ff.min_norm <= cell_in.min_norm;
      cell_ff.q_w      <= cell_in.q_w;
      cell_ff.q_x      <= cell_in.q_x;
      cell_ff.q_y      <= cell_in.q_y;
      cell_ff.q_z      <= cell_in.q_z;
      cell_ff.rem      <= cell_in.rem;
      cell_ff.root     <= cell_in.root;
   end

   assign cell_o = cell_ff;
endmodule

### rtl/core/q2rm_div_cell.sv
// One cell of the divider chain: one quotient bit for each of the four components.
// Uses q2rm_pkg.
module q2rm_div_cell #(
   parameter int Step = 0
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               vld_i,
   input  logic [q2rm_pkg::NormW-1:0]         den_i,
   input  logic [3:0][q2rm_pkg::NormW:0]      rem_i,
   input  logic [3:0][q2rm_pkg::DivSteps-1:0] num_i,
   input  logic [3:0][q2rm_pkg::DivSteps-1:0] quo_i,
   input  logic [3:0]                         neg_i,
   input  logic                               pass_i,
   output logic                               vld_o,
   output logic [q2rm_pkg::NormW-1:0]         den_o,
   output logic [3:0][q2rm_pkg::NormW:0]      rem_o,
   output logic [3:0][q2rm_pkg::DivSteps-1:0] num_o,
   output logic [3:0][q2rm_pkg::DivSteps-1:0] quo_o,
   output logic [3:0]                         neg_o,
   output logic                               pass_o
);
   localparam int NB = q2rm_pkg::DivSteps - 1 - Step;

   logic [3:0][q2rm_pkg::NormW:0]         rem_in;
   logic [3:0][q2rm_pkg::DivSteps-1:0]    quo_in;
   logic [3:0][q2rm_pkg::NormW:0]         rem_ff;
   logic [3:0][q2rm_pkg::DivSteps-1:0]    quo_ff, num_ff;
   logic [q2rm_pkg::NormW-1:0]            den_ff;
   logic [3:0]                            neg_ff;
   logic                                  vld_ff, pass_ff;
   logic [q2rm_pkg::NormW+1:0]            sh;

   // Shift in the next numerator bit, subtract when it fits
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         sh = {rem_i[k], num_i[k][NB]};
         quo_in[k] = quo_i[k];
         if (sh >= {2'b00, den_i}) begin
            rem_in[k] = (q2rm_pkg::NormW+1)'(sh - {2'b00, den_i});
            quo_in[k][NB] = 1'b1;
         end else begin
            rem_in[k] = (q2rm_pkg::NormW+1)'(sh);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_i;
      end
      den_ff  <= den_i;
      rem_ff  <= rem_in;
      num_ff  <= num_i;
      quo_ff  <= quo_in;
      neg_ff  <= neg_i;
      pass_ff <= pass_i;
   end

   assign vld_o  = vld_ff;
   assign den_o  = den_ff;
   assign rem_o  = rem_ff;
   assign num_o  = num_ff;
   assign quo_o  = quo_ff;
   assign neg_o  = neg_ff;
   assign pass_o = pass_ff;
endmodule

### rtl/core/q2rm_matrix.sv
// Matrix stage: products of normalised components, then Q.14 rounding and saturation.
// Uses q2rm_pkg.
module q2rm_matrix (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                vld_i,
   input  logic                                bad_i,
   input  logic [3:0][17:0]                    comp_i,
   output logic                                vld_o,
   output logic                                bad_o,
   output logic [8:0][q2rm_pkg::CompW-1:0]     ent_o
);
   // comp_i order: w, x, y, z; each signed 18 bits (Q3.14)
   logic signed [17:0] w, x, y, z;
   logic signed [35:0] p_ff [9];
   logic signed [35:0] p_in [9];
   logic               vld1_ff, bad1_ff, vld2_ff, bad2_ff;
   logic signed [39:0] e [9];
   logic [8:0][q2rm_pkg::CompW-1:0] ent_ff, ent_in;
   logic signed [39:0] t;
   logic signed [39:0] r;

   assign w = comp_i[0];
   assign x = comp_i[1];
   assign y = comp_i[2];
   assign z = comp_i[3];

   // Nine products: xx yy zz xy xz yz wx wy wz
   always_comb begin
      p_in[0] = x * x;
      p_in[1] = y * y;
      p_in[2] = z * z;
      p_in[3] = x * y;
      p_in[4] = x * z;
      p_in[5] = y * z;
      p_in[6] = w * x;
      p_in[7] = w * y;
      p_in[8] = w * z;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
      end else begin
         vld1_ff <= vld_i;
         vld2_ff <= vld1_ff;
      end
      bad1_ff <= bad_i;
      bad2_ff <= bad1_ff;
      p_ff    <= p_in;
      ent_ff  <= ent_in;
   end

   // Entries in Q.28, rounded half up and saturated; zero for a bad norm
   always_comb begin
      e[0] = (40'sd1 <<< 28) - 2 * (40'(p_ff[1]) + 40'(p_ff[2]));
      e[1] = 2 * (40'(p_ff[3]) - 40'(p_ff[8]));
      e[2] = 2 * (40'(p_ff[4]) + 40'(p_ff[7]));
      e[3] = 2 * (40'(p_ff[3]) + 40'(p_ff[8]));
      e[4] = (40'sd1 <<< 28) - 2 * (40'(p_ff[0]) + 40'(p_ff[2]));
      e[5] = 2 * (40'(p_ff[5]) - 40'(p_ff[6]));
      e[6] = 2 * (40'(p_ff[4]) - 40'(p_ff[7]));
      e[7] = 2 * (40'(p_ff[5]) + 40'(p_ff[6]));
      e[8] = (40'sd1 <<< 28) - 2 * (40'(p_ff[0]) + 40'(p_ff[1]));
      for (int k = 0; k < 9; k++) begin
         t = e[k] + (40'sd1 <<< 13);
         r = t >>> 14;
         if (bad1_ff) ent_in[k] = '0;
         else if (r > 40'sd32767) ent_in[k] = 16'h7fff;
         else if (r < -40'sd32768) ent_in[k] = 16'h8000;
         else ent_in[k] = r[15:0];
      end
   end

   assign vld_o = vld2_ff;
   assign bad_o = bad2_ff;
   assign ent_o = ent_ff;
endmodule

### rtl/core/quaternion_to_rotation_matrix_unit.sv
// Quaternion to 3x3 rotation matrix unit, top level.
// Depends on q2rm_pkg, q2rm_root_cell, q2rm_div_cell and q2rm_matrix.
//
// Usage:
//   Raise start with req_q_w..req_q_z for one cycle per quaternion; busy is
//   always low, so a new quaternion may be transferred every cycle.
//   Each quaternion yields one result: rsp_valid is high for one cycle with
//   rsp_m00..rsp_m22 and rsp_bad_norm; the receiver cannot stall.
//   Each quaternion passes through the entry register, the 17 root cells
//   (one root bit each), the 31 divider cells (one quotient bit each)
//   and the two-stage matrix unit. Throughput is one quaternion per cycle.
//   Config (APB): address 0 assume_unit, address 4 min_norm. The settings
//   are captured with each quaternion, so writes affect later transfers.
//   Reset (synchronous, active high) empties the pipeline and restores
//   assume_unit = 0, min_norm = 1. No clearing pass is needed.
module quaternion_to_rotation_matrix_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic signed [15:0] req_q_w,
   input  logic signed [15:0] req_q_x,
   input  logic signed [15:0] req_q_y,
   input  logic signed [15:0] req_q_z,
   output logic        rsp_valid,
   output logic signed [15:0] rsp_m00,
   output logic signed [15:0] rsp_m01,
   output logic signed [15:0] rsp_m02,
   output logic signed [15:0] rsp_m10,
   output logic signed [15:0] rsp_m11,
   output logic signed [15:0] rsp_m12,
   output logic signed [15:0] rsp_m20,
   output logic signed [15:0] rsp_m21,
   output logic signed [15:0] rsp_m22,
   output logic        rsp_bad_norm,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int RS = q2rm_pkg::RootSteps;
   localparam int DS = q2rm_pkg::DivSteps;
   localparam int NW = q2rm_pkg::NormW;

   logic                          assume_unit_ff;
   logic [q2rm_pkg::MinNormW-1:0] min_norm_ff;
   logic                          wr;

   // Configuration registers
   assign csr_pready = 1'b1;
   assign wr = csr_psel & csr_penable & csr_pwrite;
   always_ff @(posedge clock) begin
      if (reset) begin
         assume_unit_ff <= 1'b0;
         min_norm_ff    <= q2rm_pkg::MinNormW'(1);
      end else if (wr && csr_paddr[1:0] == 2'b00) begin
         if (csr_paddr[2] == q2rm_pkg::ADDR_ASSUME_UNIT) assume_unit_ff <= csr_pwdata[0];
         else min_norm_ff <= csr_pwdata[q2rm_pkg::MinNormW-1:0];
      end
   end
   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[1:0] == 2'b00) begin
         if (csr_paddr[2] == q2rm_pkg::ADDR_ASSUME_UNIT) csr_prdata[0] = assume_unit_ff;
         else csr_prdata[q2rm_pkg::MinNormW-1:0] = min_norm_ff;
      end
   end

   assign busy = 1'b0;

   // Entry stage: sum of squares
   q2rm_pkg::cell_type ent_ff;
   logic [31:0] sqw, sqx, sqy, sqz;
   always_comb begin
      sqw = 32'(req_q_w) * 32'(req_q_w);
      sqx = 32'(req_q_x) * 32'(req_q_x);
      sqy = 32'(req_q_y) * 32'(req_q_y);
      sqz = 32'(req_q_z) * 32'(req_q_z);
   end
   always_ff @(posedge clock) begin
      if (reset) ent_ff.vld <= 1'b0;
      else ent_ff.vld <= start;
      ent_ff.unit     <= assume_unit_ff;
      ent_ff.min_norm <= min_norm_ff;
      ent_ff.q_w <= req_q_w;
      ent_ff.q_x <= req_q_x;
      ent_ff.q_y <= req_q_y;
      ent_ff.q_z <= req_q_z;
      ent_ff.rem <= {1'b0, sqw} + {1'b0, sqx} + {1'b0, sqy} + {1'b0, sqz};
      ent_ff.root <= '0;
   end

   // Root chain
   q2rm_pkg::cell_type rc [RS+1];
   assign rc[0] = ent_ff;
   for (genvar g = 0; g < RS; g++) begin : g_root
      q2rm_root_cell #(.Step(g)) u_cell (
         .clock(clock), .reset(reset), .cell_i(rc[g]), .cell_o(rc[g+1]));
   end

   // Divider chain set-up
   logic                     dv  [DS+1];
   logic [NW-1:0]            dd  [DS+1];
   logic [3:0][NW:0]         dr  [DS+1];
   logic [3:0][DS-1:0]       dn  [DS+1];
   logic [3:0][DS-1:0]       dq  [DS+1];
   logic [3:0]               dneg[DS+1];
   logic                     dp  [DS+1];
   logic                     bad_rt;
   logic signed [15:0]       qc [4];

   assign qc[0] = rc[RS].q_w;
   assign qc[1] = rc[RS].q_x;
   assign qc[2] = rc[RS].q_y;
   assign qc[3] = rc[RS].q_z;
   assign bad_rt = ~rc[RS].unit &&
      (rc[RS].root == '0 || rc[RS].root < {2'b00, rc[RS].min_norm});

   // Unit mode: divide c*2^14 by 2^12 = c*4; bad norm: divide by 1 and zero later
   always_comb begin
      dv[0] = rc[RS].vld;
      dp[0] = bad_rt;
      if (rc[RS].unit) dd[0] = NW'(4096);
      else if (bad_rt) dd[0] = NW'(1);
      else dd[0] = rc[RS].root;
      for (int k = 0; k < 4; k++) begin
         dneg[0][k] = qc[k][15];
         dr[0][k]   = '0;
         dq[0][k]   = '0;
         dn[0][k]   = DS'(qc[k][15] ? -17'(qc[k]) : 17'(qc[k])) << 14;
      end
   end

   for (genvar g = 0; g < DS; g++) begin : g_div
      q2rm_div_cell #(.Step(g)) u_cell (
         .clock(clock), .reset(reset),
         .vld_i(dv[g]), .den_i(dd[g]), .rem_i(dr[g]), .num_i(dn[g]),
         .quo_i(dq[g]), .neg_i(dneg[g]), .pass_i(dp[g]),
         .vld_o(dv[g+1]), .den_o(dd[g+1]), .rem_o(dr[g+1]), .num_o(dn[g+1]),
         .quo_o(dq[g+1]), .neg_o(dneg[g+1]), .pass_o(dp[g+1]));
   end

   // Signed components, 18 bits
   logic [3:0][17:0] comp;
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         comp[k] = dneg[DS][k] ? -dq[DS][k][17:0] : dq[DS][k][17:0];
      end
   end

   logic [8:0][15:0] ent;
   q2rm_matrix u_matrix (
      .clock(clock), .reset(reset), .vld_i(dv[DS]), .bad_i(dp[DS]),
      .comp_i(comp), .vld_o(rsp_valid), .bad_o(rsp_bad_norm), .ent_o(ent));

   assign rsp_m00 = ent[0];
   assign rsp_m01 = ent[1];
   assign rsp_m02 = ent[2];
   assign rsp_m10 = ent[3];
   assign rsp_m11 = ent[4];
   assign rsp_m12 = ent[5];
   assign rsp_m20 = ent[6];
   assign rsp_m21 = ent[7];
   assign rsp_m22 = ent[8];
endmodule

### rtl/core/q2rm_checker.sv
// Port-level checker for the quaternion to rotation matrix unit, with its bind.
// Depends only on the top level's ports.
module q2rm_port_checker (
   input logic        clock,
   input logic        reset,
   input logic        busy,
   input logic        rsp_valid,
   input logic        rsp_bad_norm,
   input logic [15:0] rsp_m00,
   input logic [15:0] rsp_m11,
   input logic        csr_pready
);
   ap_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");
   ap_ready: assert property (@(posedge clock) csr_pready)
      else $error("pready low");
   ap_bad: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_norm |-> rsp_m00 == 16'h0 && rsp_m11 == 16'h0)
      else $error("bad norm with non-zero matrix");
   ap_rst: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result after reset");
endmodule

bind quaternion_to_rotation_matrix_unit q2rm_port_checker u_q2rm_port_checker (
   .clock(clock), .reset(reset), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_bad_norm(rsp_bad_norm),
   .rsp_m00(rsp_m00), .rsp_m11(rsp_m11), .csr_pready(csr_pready));

### test/q2rm_checker.sv
// Checker for the quaternion to rotation matrix unit: predicts each matrix
// from the transferred quaternion and the register settings, compares results.
// Depends on the unit's port list and q2rm_pkg.
module q2rm_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic signed [15:0] q_w,
   input  logic signed [15:0] q_x,
   input  logic signed [15:0] q_y,
   input  logic signed [15:0] q_z,
   input  logic               rsp_valid,
   input  logic signed [15:0] rsp_m [9],
   input  logic               rsp_bad_norm,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic               csr_pready,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output int                 fail_count,
   output int                 pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] AddrAssumeUnit = {q2rm_pkg::ADDR_ASSUME_UNIT, 2'b00};
   localparam logic [2:0] AddrMinNorm    = {q2rm_pkg::ADDR_MIN_NORM, 2'b00};

   typedef struct {
      logic signed [15:0] m [9];
      logic               bad;
   } matrix_type;

   matrix_type  matrix_queue[$];
   logic        unit_mode;
   logic [14:0] min_norm;

   function automatic longint root_floor(longint s);
      longint r, b;
      r = 0;
      b = 64'sd1 << 34;
      while (b > s) b = b >>> 2;
      while (b != 0) begin
         if (s >= r + b) begin
            s = s - (r + b);
            r = (r >>> 1) + b;
         end else begin
            r = r >>> 1;
         end
         b = b >>> 2;
      end
      return r;
   endfunction

   // c * 2^14 / n truncated toward zero
   function automatic longint scale_div(longint c, longint n);
      longint q;
      q = ((c < 0 ? -c : c) <<< 14) / n;
      return c < 0 ? -q : q;
   endfunction

   // Q.28 to Q.14, round half up, saturate
   function automatic logic signed [15:0] round_sat(longint v);
      longint t, r;
      t = v + 8192;
      r = t >>> 14;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r[15:0];
   endfunction

   function automatic matrix_type rotation_of(longint w, longint x, longint y, longint z);
      matrix_type o;
      longint s, n, one;
      longint e [9];
      one = 64'sd1 << 28;
      o.bad = 1'b0;
      if (unit_mode) begin
         w *= 4; x *= 4; y *= 4; z *= 4;
      end else begin
         s = w*w + x*x + y*y + z*z;
         n = root_floor(s);
         if (n == 0 || n < min_norm) begin
            foreach (o.m[i]) o.m[i] = '0;
            o.bad = 1'b1;
            return o;
         end
         w = scale_div(w, n); x = scale_div(x, n);
         y = scale_div(y, n); z = scale_div(z, n);
      end
      e[0] = one - 2*(y*y + z*z);
      e[1] = 2*(x*y - w*z);
      e[2] = 2*(x*z + w*y);
      e[3] = 2*(x*y + w*z);
      e[4] = one - 2*(x*x + z*z);
      e[5] = 2*(y*z - w*x);
      e[6] = 2*(x*z - w*y);
      e[7] = 2*(y*z + w*x);
      e[8] = one - 2*(x*x + y*y);
      foreach (e[i]) o.m[i] = round_sat(e[i]);
      return o;
   endfunction

   task automatic report_mismatch(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      fail_count++;
   endtask

   assign pending = matrix_queue.size();

   always @(posedge clock) begin
      matrix_type want;
      if (reset) begin
         unit_mode  = 1'b0;
         min_norm   = 15'd1;
         fail_count = 0;
         matrix_queue.delete();
      end else begin
         // results first: a transfer this edge cannot produce a result yet
         if (rsp_valid) begin
            if (matrix_queue.size() == 0) begin
               report_mismatch("result with none expected");
            end else begin
               want = matrix_queue.pop_front();
               foreach (want.m[i])
                  if (rsp_m[i] !== want.m[i])
                     report_mismatch($sformatf("m%0d%0d got %0d want %0d",
                        i / 3, i % 3, rsp_m[i], want.m[i]));
               if (rsp_bad_norm !== want.bad)
                  report_mismatch($sformatf("bad_norm got %b want %b",
                     rsp_bad_norm, want.bad));
            end
         end
         if (start && !busy)
            matrix_queue.push_back(rotation_of(q_w, q_x, q_y, q_z));
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr == AddrAssumeUnit) unit_mode = csr_pwdata[0];
            else if (csr_paddr == AddrMinNorm) min_norm = csr_pwdata[14:0];
         end
      end
   end
endmodule

### test/testbench.sv
// Top of the quaternion to rotation matrix testbench: clock, reset, stimulus
// and verdict. Depends on quaternion_to_rotation_matrix_unit, q2rm_checker and q2rm_pkg.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] AddrAssumeUnit = {q2rm_pkg::ADDR_ASSUME_UNIT, 2'b00};
   localparam logic [2:0] AddrMinNorm    = {q2rm_pkg::ADDR_MIN_NORM, 2'b00};
   localparam int Latency   = 51;
   localparam int CycleCap  = 200000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [15:0] q_w = '0, q_x = '0, q_y = '0, q_z = '0;
   logic rsp_valid, rsp_bad_norm;
   logic signed [15:0] rsp_m [9];
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [2:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;
   int fail_count, pending;
   int cycles = 0;
   int idle_pct = 0;

   always #5 clock = ~clock;

   quaternion_to_rotation_matrix_unit dut (
      .clock, .reset, .start, .busy,
      .req_q_w(q_w), .req_q_x(q_x), .req_q_y(q_y), .req_q_z(q_z),
      .rsp_valid,
      .rsp_m00(rsp_m[0]), .rsp_m01(rsp_m[1]), .rsp_m02(rsp_m[2]),
      .rsp_m10(rsp_m[3]), .rsp_m11(rsp_m[4]), .rsp_m12(rsp_m[5]),
      .rsp_m20(rsp_m[6]), .rsp_m21(rsp_m[7]), .rsp_m22(rsp_m[8]),
      .rsp_bad_norm,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata,
      .csr_prdata, .csr_pready
   );

   q2rm_checker checker_i (
      .clock, .reset, .start, .busy, .q_w, .q_x, .q_y, .q_z,
      .rsp_valid, .rsp_m, .rsp_bad_norm,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_pready, .csr_paddr, .csr_pwdata,
      .fail_count, .pending
   );

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleCap) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   task automatic write_reg(logic [2:0] addr, logic [31:0] data);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_paddr <= addr; csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
   endtask

   // one quaternion transfer, with random idle cycles ahead of it
   task automatic send(logic [15:0] w, logic [15:0] x, logic [15:0] y, logic [15:0] z);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      q_w <= w; q_x <= x; q_y <= y; q_z <= z;
      do @(posedge clock); while (busy);
   endtask

   task automatic drain;
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [15:0] rand_comp(int mode);
      case (mode)
         0: return 16'($urandom());
         1: return 16'($urandom_range(8192) - 4096);
         2: return 16'($urandom_range(64) - 32);
         default: return $urandom_range(1) ? 16'h8000 : 16'h7FFF;
      endcase
   endfunction

   task automatic random_phase(int count);
      int mode;
      for (int i = 0; i < count; i++) begin
         mode = $urandom_range(9);
         mode = mode < 4 ? 0 : mode < 8 ? 1 : mode < 9 ? 2 : 3;
         send(rand_comp(mode), rand_comp(mode), rand_comp(mode), rand_comp(mode));
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: identity, axes, extremes, zero norm, tiny norm
      send(16'sd4096, 0, 0, 0);
      send(0, 16'sd4096, 0, 0);
      send(0, 0, 16'sd4096, 0);
      send(0, 0, 0, 16'sd4096);
      send(16'sd2896, 16'sd2896, 0, 0);
      send(0, 0, 0, 0);
      send(16'sd1, 0, 0, 0);
      send(16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      send(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
      send(-16'sd2048, 16'sd2048, -16'sd2048, 16'sd2048);
      drain();
      write_reg(AddrMinNorm, 32'd0);
      send(0, 0, 0, 0);
      send(0, 0, 16'sd1, 0);
      drain();
      write_reg(AddrMinNorm, 32'h7FFF);
      send(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      send(16'sd4096, 0, 0, 0);
      send(16'h8000, 16'h8000, 16'h8000, 16'h8000);
      drain();
      write_reg(AddrAssumeUnit, 32'd1);
      send(16'sd4096, 0, 0, 0);
      send(0, 0, 0, 0);
      send(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
      send(16'h8000, 16'h8000, 16'h8000, 16'h8000);
      drain();

      // random phases over several settings and idling patterns
      idle_pct = 34;
      write_reg(AddrAssumeUnit, 32'd0);
      write_reg(AddrMinNorm, 32'd1);
      random_phase(150);
      drain();
      idle_pct = 64;
      write_reg(AddrMinNorm, 32'd3000);
      random_phase(100);
      drain();
      write_reg(AddrAssumeUnit, 32'd1);
      random_phase(100);
      drain();
      idle_pct = 0;
      write_reg(AddrAssumeUnit, 32'd0);
      write_reg(AddrMinNorm, $urandom_range(200));
      random_phase(150);
      drain();

      repeat (Latency + 10) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end
endmodule
